### hw/rtl/smtd_pkg.sv
// Shared types, constants and helper functions for the temperature attribute decoder.
// Used by smtd_decode and smart_temperature_minmax_decoder_core; no dependencies.
package smtd_pkg;

    localparam int RAW_W = 48;

    localparam logic signed [7:0] TEMP_LOW_LIMIT  = -8'sd60;
    localparam logic signed [7:0] TEMP_HIGH_LIMIT = 8'sd120;
    localparam logic signed [7:0] TEMP_MINUS_ONE  = -8'sd1;
    localparam logic signed [7:0] TEMP_ZERO       = 8'sd0;
    localparam logic signed [7:0] COUNT_MAX_MIN   = 8'sd40;
    localparam logic [15:0]       COUNT_LIMIT     = 16'h7fff;

    localparam logic [15:0] WORD_POS_MAX  = 16'h007f;
    localparam logic [15:0] WORD_BYTE_MAX = 16'h00ff;
    localparam logic [15:0] WORD_NEG_MIN  = 16'hff80;

    localparam logic [4:0] CLASS_POS  = 5'h11;
    localparam logic [4:0] CLASS_BYTE = 5'h01;
    localparam logic [4:0] CLASS_NEG  = 5'h10;
    localparam logic [4:0] CLASS_NONE = 5'h00;

    typedef enum logic [2:0] {
        LAYOUT_PLAIN    = 3'd0,
        LAYOUT_PAIR_23  = 3'd1,
        LAYOUT_PAIR_12  = 3'd2,
        LAYOUT_PAIR_24  = 3'd3,
        LAYOUT_COUNT    = 3'd4,
        LAYOUT_UNK_ZERO = 3'd5,
        LAYOUT_UNK_TEMP = 3'd6,
        LAYOUT_UNK_RAW  = 3'd7
    } layout_t;

    typedef struct packed {
        logic              ok;
        logic signed [7:0] lo;
        logic signed [7:0] hi;
    } pair_t;

    typedef struct packed {
        logic signed [7:0] current_temp;
        logic signed [7:0] min_temp;
        logic signed [7:0] max_temp;
        layout_t           layout_code;
        logic [15:0]       event_count;
    } result_t;

    function automatic logic [4:0] word_class(input logic [15:0] w);
        logic [4:0] c;
        if (w <= WORD_POS_MAX)
            c = CLASS_POS;
        else if (w <= WORD_BYTE_MAX)
            c = CLASS_BYTE;
        else if (w >= WORD_NEG_MIN)
            c = CLASS_NEG;
        else
            c = CLASS_NONE;
        return c;
    endfunction

    function automatic pair_t pair_check(input logic signed [7:0] cur,
                                         input logic [7:0] a,
                                         input logic [7:0] b);
        logic signed [7:0] x;
        logic signed [7:0] y;
        pair_t             r;
        x = signed'(a);
        y = signed'(b);
        if (x > y)
        begin
            r.lo = y;
            r.hi = x;
        end
        else
        begin
            r.lo = x;
            r.hi = y;
        end
        r.ok = (r.lo >= TEMP_LOW_LIMIT) && (r.lo <= cur) && (cur <= r.hi)
            && (r.hi <= TEMP_HIGH_LIMIT)
            && !((r.lo == TEMP_MINUS_ONE) && (r.hi <= TEMP_ZERO));
        return r;
    endfunction

endpackage

### hw/rtl/smtd_decode.sv
// Combinational layout classifier for one six-byte temperature attribute.
// Depends on smtd_pkg for types, limits and the pair/word helpers.
module smtd_decode
(
    input  logic [smtd_pkg::RAW_W-1:0] raw_bytes,
    output smtd_pkg::result_t          result
);

    logic [7:0]         b0, b1, b2, b3, b4;
    logic [15:0]        w0, w1, w2;
    logic signed [7:0]  cur;
    logic [4:0]         c0, c1, c2;
    smtd_pkg::pair_t    p23, p12, p24;
    smtd_pkg::layout_t  layout;

    assign b0  = raw_bytes[7:0];
    assign b1  = raw_bytes[15:8];
    assign b2  = raw_bytes[23:16];
    assign b3  = raw_bytes[31:24];
    assign b4  = raw_bytes[39:32];
    assign w0  = raw_bytes[15:0];
    assign w1  = raw_bytes[31:16];
    assign w2  = raw_bytes[47:32];
    assign cur = signed'(b0);

    assign c0  = smtd_pkg::word_class(w0);
    assign c1  = smtd_pkg::word_class(w1);
    assign c2  = smtd_pkg::word_class(w2);
    assign p23 = smtd_pkg::pair_check(cur, b2, b3);
    assign p12 = smtd_pkg::pair_check(cur, b1, b2);
    assign p24 = smtd_pkg::pair_check(cur, b2, b4);

    always_comb
    begin
        if (w2 == 16'd0)
        begin
            if ((w1 == 16'd0) && (c0 != smtd_pkg::CLASS_NONE))
                layout = smtd_pkg::LAYOUT_PLAIN;
            else if ((c0 != smtd_pkg::CLASS_NONE) && p23.ok)
                layout = smtd_pkg::LAYOUT_PAIR_23;
            else if ((b3 == 8'd0) && p12.ok)
                layout = smtd_pkg::LAYOUT_PAIR_12;
            else
                layout = smtd_pkg::LAYOUT_UNK_ZERO;
        end
        else if (c0 != smtd_pkg::CLASS_NONE)
        begin
            if (((c0 & c1 & c2) != smtd_pkg::CLASS_NONE) && p24.ok)
                layout = smtd_pkg::LAYOUT_PAIR_24;
            else if ((w2 < smtd_pkg::COUNT_LIMIT) && p23.ok
                     && (p23.hi >= smtd_pkg::COUNT_MAX_MIN))
                layout = smtd_pkg::LAYOUT_COUNT;
            else
                layout = smtd_pkg::LAYOUT_UNK_TEMP;
        end
        else
        begin
            layout = smtd_pkg::LAYOUT_UNK_RAW;
        end
    end

    always_comb
    begin
        result.current_temp = cur;
        result.layout_code  = layout;
        result.event_count  = 16'd0;
        case (layout)
            smtd_pkg::LAYOUT_PAIR_23:
            begin
                result.min_temp = p23.lo;
                result.max_temp = p23.hi;
            end
            smtd_pkg::LAYOUT_PAIR_12:
            begin
                result.min_temp = p12.lo;
                result.max_temp = p12.hi;
            end
            smtd_pkg::LAYOUT_PAIR_24:
            begin
                result.min_temp = p24.lo;
                result.max_temp = p24.hi;
            end
            smtd_pkg::LAYOUT_COUNT:
            begin
                result.min_temp    = p23.lo;
                result.max_temp    = p23.hi;
                result.event_count = w2;
            end
            default:
            begin
                result.min_temp = smtd_pkg::TEMP_ZERO;
                result.max_temp = smtd_pkg::TEMP_ZERO;
            end
        endcase
    end

endmodule

### hw/rtl/smart_temperature_minmax_decoder_core.sv
// Top level of the temperature attribute decoder: input register, decode, result register.
// Depends on smtd_pkg and smtd_decode.
//
// Each beat on raw_bytes yields exactly one result beat, held in the input register until
// the result register, which drives result_valid, is free. One beat is taken per cycle
// while raw_ready is high: the decode is a single short combinational path between the
// input register and the result register, and the two registers form a two-entry
// pipeline. raw_ready drops only while both registers hold a beat and result_ready is low.
module smart_temperature_minmax_decoder_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          raw_valid,
    output logic                          raw_ready,
    input  logic [smtd_pkg::RAW_W-1:0]    raw_bytes,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic signed [7:0]             current_temp,
    output logic signed [7:0]             min_temp,
    output logic signed [7:0]             max_temp,
    output logic [2:0]                    layout_code,
    output logic [15:0]                   event_count
);

    logic                       in_valid_reg;
    logic [smtd_pkg::RAW_W-1:0] raw_reg;
    logic                       out_valid_reg;
    smtd_pkg::result_t          result_reg;
    smtd_pkg::result_t          result_next;
    logic                       out_ready;
    logic                       in_ready;

    assign out_ready = !out_valid_reg || result_ready;
    assign in_ready  = !in_valid_reg || out_ready;
    assign raw_ready = in_ready;

    // hold input beat until the result stage frees up
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= raw_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && raw_valid)
            raw_reg <= raw_bytes;
    end

    smtd_decode u_decode
    (
        .raw_bytes (raw_reg),
        .result    (result_next)
    );

    // advance decoded beat into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_ready)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && in_valid_reg)
            result_reg <= result_next;
    end

    assign result_valid = out_valid_reg;
    assign current_temp = result_reg.current_temp;
    assign min_temp     = result_reg.min_temp;
    assign max_temp     = result_reg.max_temp;
    assign layout_code  = result_reg.layout_code;
    assign event_count  = result_reg.event_count;

    a_pair_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (layout_code != smtd_pkg::LAYOUT_PAIR_23)
            && (layout_code != smtd_pkg::LAYOUT_PAIR_12)
            && (layout_code != smtd_pkg::LAYOUT_PAIR_24)
            && (layout_code != smtd_pkg::LAYOUT_COUNT))
        |-> (min_temp == smtd_pkg::TEMP_ZERO) && (max_temp == smtd_pkg::TEMP_ZERO))
        else $error("min/max nonzero without a recognized pair");

    a_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (layout_code != smtd_pkg::LAYOUT_COUNT)) |-> (event_count == 16'd0))
        else $error("count word outside count layout");

    a_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (min_temp <= max_temp))
        else $error("min above max");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_ready) |=> (in_valid_reg && $stable(raw_reg)))
        else $error("input stage lost a stalled beat");

    a_in_take: assert property (@(posedge clk) disable iff (!rst_n)
        (raw_valid && raw_ready) |=> in_valid_reg)
        else $error("accepted beat not captured");

endmodule
